[src/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/itoa_pkg.sv]
// Shared constants, types and the digit-to-character function of the
// integer to ASCII radix converter. No dependencies.
package itoa_pkg;

    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_MAX_DIGITS = 32;
    localparam int IN_VALUE_W     = 32;
    localparam int RADIX_W        = 6;
    localparam int DIGIT_W        = 6;
    localparam int CHAR_W         = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
    localparam logic [CHAR_W-1:0]  CH_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0]  CH_NINE    = 7'h39;
    localparam logic [CHAR_W-1:0]  LETTER_GAP = 7'd7;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic next;
        logic rd;
        logic back;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic q_zero;
        logic ptr_full;
        logic ptr_zero;
    } t_sts;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        c = {1'b0, d} + CH_ZERO;
        if (c > CH_NINE) begin
            c = c + LETTER_GAP;
        end
        return c;
    endfunction

endpackage

[src/itoa_ctrl.sv]
// Controller state machine of the converter: sequences load, divide,
// digit store and character output. Depends on itoa_pkg.
module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (i_sts.q_zero || i_sts.ptr_full) begin
                    n_state = S_READ;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (i_sts.ptr_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.back = 1'b1;
                        n_state    = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

[src/itoa_datapath.sv]
// Datapath of the converter: bit-serial restoring divider, digit buffer
// and character formatting. Depends on itoa_pkg.
module itoa_datapath
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic                  i_clk,
    input  logic [IN_VALUE_W-1:0] i_value,
    input  logic [RADIX_W-1:0]    i_radix,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [CHAR_W-1:0]     o_character,
    output logic                  o_last
);

    localparam int LOAD_BITS = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
    localparam int BCW       = $clog2(VALUE_BITS);
    localparam int IW        = $clog2(MAX_DIGITS);

    logic [VALUE_BITS-1:0] r_quot;
    logic [DIGIT_W-1:0]    r_rem;
    logic [RADIX_W-1:0]    r_radix;
    logic [BCW-1:0]        r_bitcnt;
    logic [IW-1:0]         r_ptr;
    logic [DIGIT_W-1:0]    r_rd_data;
    logic [DIGIT_W-1:0]    r_mem [MAX_DIGITS];

    logic [VALUE_BITS-1:0] load_val;
    logic [RADIX_W-1:0]    radix_clamped;
    logic [DIGIT_W:0]      rem_sh;
    logic [DIGIT_W:0]      rem_diff;
    logic                  ge;

    always_comb begin
        load_val                = '0;
        load_val[LOAD_BITS-1:0] = i_value[LOAD_BITS-1:0];
        if (i_radix < RADIX_MIN) begin
            radix_clamped = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            radix_clamped = RADIX_MAX;
        end else begin
            radix_clamped = i_radix;
        end
    end

    assign rem_sh   = {r_rem, r_quot[VALUE_BITS-1]};
    assign ge       = (rem_sh >= {1'b0, r_radix});
    assign rem_diff = rem_sh - {1'b0, r_radix};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot   <= load_val;
            r_radix  <= radix_clamped;
            r_rem    <= '0;
            r_bitcnt <= '0;
            r_ptr    <= '0;
        end else if (i_cmd.step) begin
            r_quot   <= {r_quot[VALUE_BITS-2:0], ge};
            r_rem    <= ge ? rem_diff[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
            r_bitcnt <= r_bitcnt + 1'b1;
        end else if (i_cmd.store) begin
            r_rem    <= '0;
            r_bitcnt <= '0;
            if (i_cmd.next) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end else if (i_cmd.back) begin
            r_ptr <= r_ptr - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_ptr] <= r_rem;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    assign o_sts.div_last = (r_bitcnt == BCW'(VALUE_BITS - 1));
    assign o_sts.q_zero   = (r_quot == '0);
    assign o_sts.ptr_full = (r_ptr == IW'(MAX_DIGITS - 1));
    assign o_sts.ptr_zero = (r_ptr == '0);

    assign o_character = digit_to_char(r_rd_data);
    assign o_last      = (r_ptr == '0);

endmodule

[src/integer_to_ascii_radix_unit.sv]
// Top level of the integer to ASCII radix converter: controller plus datapath.
// Depends on itoa_pkg, itoa_ctrl and itoa_datapath.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall   i_value[31:0], i_radix[5:0]
//   output   out        o_out_valid / i_out_stall o_character[6:0], o_last
//
// Per digit the shared bit-serial divider steps through VALUE_BITS quotient bits,
// then stores the digit; each character is then read from the buffer and output.
// One transaction is converted at a time; o_in_stall is high until the last
// character is taken. Reset is synchronous, active low, and returns to idle.
// An output stall holds the current character and pauses the output sequence.
module integer_to_ascii_radix_unit
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [IN_VALUE_W-1:0] i_value,
    input  logic [RADIX_W-1:0]    i_radix,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CHAR_W-1:0]     o_character,
    output logic                  o_last
);

    t_cmd cmd;
    t_sts sts;

    itoa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    itoa_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

[src/itoa_checker.sv]
// Port-level checker for the converter and its bind to the top level.
// Depends on assert_macros.svh and itoa_pkg.
`include "assert_macros.svh"

module itoa_checker
    import itoa_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [CHAR_W-1:0] o_character,
    input logic              o_last
);

    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "input not stalled after accepted transaction")
    `ASSERT_CLK(a_out_while_busy, i_clk, i_rst_n, o_out_valid |-> o_in_stall, "input open while characters pending")
    `ASSERT_CLK(a_char_range, i_clk, i_rst_n, o_out_valid |-> ((o_character >= 7'h30 && o_character <= 7'h39) || (o_character >= 7'h41 && o_character <= 7'h5A)), "character outside digit range")
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_character) && $stable(o_last), "stalled output changed")

endmodule

bind integer_to_ascii_radix_unit itoa_checker u_itoa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_character (o_character),
    .o_last      (o_last)
);

[test/tb_top.sv]
// Self-checking testbench for integer_to_ascii_radix_unit: directed and random numbers,
// expected characters predicted in the testbench, random input gaps and output stalls.
// Depends on itoa_pkg and integer_to_ascii_radix_unit.
module tb_top;
    import itoa_pkg::*;

    localparam int DIGITS         = DEF_MAX_DIGITS;
    localparam int RAND_ITEMS     = 344;
    localparam int HOLD_CYCLES    = 3000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_MAX     = 10;
    localparam logic [CHAR_W-1:0] CH_ALPHA = 7'h41;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_exp;

    typedef struct {
        logic [IN_VALUE_W-1:0] value;
        logic [RADIX_W-1:0]    radix;
        string                 text;
    } t_number_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [IN_VALUE_W-1:0] i_value;
    logic [RADIX_W-1:0]    i_radix;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CHAR_W-1:0]     o_character;
    logic                  o_last;

    t_char_exp pending_chars[$];
    int        error_count    = 0;
    int        numbers_sent   = 0;
    int        odd_radix_sent = 0;
    int        chars_checked  = 0;
    int        quiet_cycles   = 0;
    bit        no_idle        = 1'b0;
    bit        hold_req       = 1'b0;

    // empty text: expected characters come from the predictor
    t_number_row directed_numbers [25] = '{
        '{32'd0,          6'd10, "0"},
        '{32'd0,          6'd0,  "0"},
        '{32'd0,          6'd63, "0"},
        '{32'd1,          6'd2,  "1"},
        '{32'hFFFFFFFF,   6'd2,  "11111111111111111111111111111111"},
        '{32'h80000000,   6'd2,  "10000000000000000000000000000000"},
        '{32'hFFFFFFFF,   6'd10, "4294967295"},
        '{32'hFFFFFFFF,   6'd16, "FFFFFFFF"},
        '{32'hFFFFFFFF,   6'd8,  "37777777777"},
        '{32'hFFFFFFFF,   6'd36, ""},
        '{32'hFFFFFFFF,   6'd3,  ""},
        '{32'd35,         6'd36, "Z"},
        '{32'd36,         6'd36, "10"},
        '{32'd10,         6'd11, "A"},
        '{32'd9,          6'd10, "9"},
        '{32'd5,          6'd1,  "101"},
        '{32'd5,          6'd0,  "101"},
        '{32'd35,         6'd63, "Z"},
        '{32'd36,         6'd37, "10"},
        '{32'h12345678,   6'd16, "12345678"},
        '{32'hDEADBEEF,   6'd16, "DEADBEEF"},
        '{32'h7FFFFFFF,   6'd10, "2147483647"},
        '{32'hAAAAAAAA,   6'd35, ""},
        '{32'h55555555,   6'd7,  ""},
        '{32'd1234567890, 6'd33, ""}
    };

    integer_to_ascii_radix_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_base(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN) return 32'(RADIX_MIN);
        if (r > RADIX_MAX) return 32'(RADIX_MAX);
        return 32'(r);
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
        if (d < 10) return CHAR_W'(CH_ZERO + d);
        return CHAR_W'(CH_ALPHA + d - 10);
    endfunction

    task automatic predict_number(input logic [IN_VALUE_W-1:0] v,
                                  input logic [RADIX_W-1:0] r);
        int unsigned           base;
        int unsigned           digs [DIGITS];
        logic [IN_VALUE_W-1:0] q;
        int                    n;
        base = clamp_base(r);
        q    = v;
        n    = 0;
        do begin
            digs[n] = q % base;
            q       = q / base;
            n++;
        end while (q != 0 && n < DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            pending_chars.push_back('{digit_char(digs[k]), k == 0});
        end
    endtask

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX) begin
            $display("mismatch: %s", msg);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [RADIX_W-1:0] pick_radix();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
        if (r < 80) return RADIX_W'($urandom_range(0, 63));
        case ($urandom_range(0, 4))
            0: return 6'd2;
            1: return 6'd8;
            2: return 6'd10;
            3: return 6'd16;
            default: return 6'd36;
        endcase
    endfunction

    function automatic logic [IN_VALUE_W-1:0] pick_value(input int unsigned base);
        longint unsigned p;
        int              r;
        r = $urandom_range(0, 99);
        if (r < 35) return $urandom;
        if (r < 55) return $urandom_range(0, 1000);
        if (r < 80) begin
            // around a power of the base: digit count boundaries
            p = 1;
            repeat ($urandom_range(1, 32)) begin
                if (p * base <= 64'hFFFFFFFF) p = p * base;
            end
            return IN_VALUE_W'(p + $urandom_range(0, 2) - 1);
        end
        if (r < 90) begin
            case ($urandom_range(0, 2))
                0: return '0;
                1: return 32'd1;
                default: return '1;
            endcase
        end
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // one transaction on the input side, then an optional idle gap
    task automatic offer_number(input logic [IN_VALUE_W-1:0] v, input logic [RADIX_W-1:0] r,
                                input string text, input int gap);
        byte c;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_radix    <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (text.len() == 0) begin
            predict_number(v, r);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                c = text.getc(i);
                pending_chars.push_back('{c[CHAR_W-1:0], i == text.len() - 1});
            end
        end
        numbers_sent++;
        if (r < RADIX_MIN || r > RADIX_MAX) odd_radix_sent++;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // output side stall pattern
    initial begin
        int stall_left;
        int open_left;
        i_out_stall = 1'b0;
        stall_left  = 0;
        open_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
                open_left  = 0;
            end
            if (stall_left == 0 && open_left == 0) begin
                if (no_idle) begin
                    open_left = 1;
                end else if ($urandom_range(0, 99) < 60) begin
                    open_left = $urandom_range(1, 12);
                end else if ($urandom_range(0, 9) < 8) begin
                    stall_left = $urandom_range(1, 3);
                end else begin
                    stall_left = $urandom_range(15, 80);
                end
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                open_left--;
            end
        end
    end

    always @(posedge i_clk) begin : char_check
        t_char_exp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                report_error($sformatf("character %c last=%0b with no number pending",
                                       o_character, o_last));
            end else begin
                want = pending_chars.pop_front();
                if (o_character !== want.ch || o_last !== want.last) begin
                    report_error($sformatf("expected %c last=%0b, got %c (%0h) last=%0b",
                                           want.ch, want.last, o_character, o_character, o_last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [RADIX_W-1:0] r;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_value    = '0;
        i_radix    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_numbers[i]) begin
            offer_number(directed_numbers[i].value, directed_numbers[i].radix,
                         directed_numbers[i].text, pick_gap());
        end

        // receiver holds off while the sender keeps offering back to back
        hold_req = 1'b1;
        repeat (4) offer_number(pick_value(10), 6'd10, "", 0);

        // sender waits for a full drain
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            no_idle = ((n / 40) % 3 == 1);
            r = pick_radix();
            offer_number(pick_value(clamp_base(r)), r, "", pick_gap());
        end
        no_idle = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            report_error($sformatf("%0d characters never arrived", pending_chars.size()));
        end

        $display("%0d numbers converted (%0d with a radix code outside 2..36), %0d characters",
                 numbers_sent, odd_radix_sent, chars_checked);
        $display("%0d mismatches", error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
